>>> rtl/chunked_transfer_encoder_macros.svh
// Assertion macros shared by the chunked transfer encoder RTL.
`ifndef CHUNKED_TRANSFER_ENCODER_MACROS_SVH
`define CHUNKED_TRANSFER_ENCODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CTE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cte assertion failed");

// Next-cycle implication, checked out of reset.
`define CTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cte assertion failed");

`endif

>>> rtl/cte_pkg.sv
// Types, constants and microcode program of the chunked transfer encoder.
package cte_pkg;

  localparam int MAX_CHUNK = 32;
  localparam int BUF_AW    = $clog2(MAX_CHUNK);
  localparam int CNT_W     = $clog2(MAX_CHUNK + 1);
  localparam int CFG_W     = 6;
  localparam int PC_W      = 4;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_ZERO = 8'h30;

  // program entry points
  localparam logic [PC_W-1:0] PC_CHUNK = 4'd0;
  localparam logic [PC_W-1:0] PC_BUF   = 4'd7;
  localparam logic [PC_W-1:0] PC_TERM  = 4'd10;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } cte_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } cte_out_t;

  typedef enum logic [1:0] {SRC_CONST, SRC_HEX, SRC_BUF} cte_src_t;
  typedef enum logic [1:0] {JMP_NEXT, JMP_LOOP, JMP_TERM, JMP_END} cte_jmp_t;
  typedef enum logic [1:0] {LAST_NO, LAST_CHUNK, LAST_YES} cte_last_t;
  typedef enum logic {SEQ_IDLE, SEQ_RUN} cte_state_t;

  typedef struct packed {
    cte_src_t        src;
    logic [7:0]      const_byte;
    logic [2:0]      nib;
    logic            rd_clear;
    logic            rd_inc;
    cte_last_t       last;
    cte_jmp_t        jmp;
    logic [PC_W-1:0] target;
  } cte_ucode_t;

  typedef struct packed {
    logic            go;
    logic            flush;
    logic [PC_W-1:0] addr;
  } cte_start_t;

  typedef struct packed {
    logic       busy;
    logic       fire;
    cte_src_t   src;
    logic [7:0] const_byte;
    logic [2:0] nib;
    logic       rd_clear;
    logic       rd_inc;
    logic       last;
  } cte_ctrl_t;

  function automatic cte_ucode_t uc(cte_src_t src, logic [7:0] cb, logic [2:0] nib,
                                    logic rc, logic ri, cte_last_t lst, cte_jmp_t jmp,
                                    logic [PC_W-1:0] tgt);
    cte_ucode_t w;
    w.src        = src;
    w.const_byte = cb;
    w.nib        = nib;
    w.rd_clear   = rc;
    w.rd_inc     = ri;
    w.last       = lst;
    w.jmp        = jmp;
    w.target     = tgt;
    return w;
  endfunction

  // Microcode: length digits, CR LF, data loop, CR LF, then the terminator on flush.
  function automatic cte_ucode_t ucode_rom(logic [PC_W-1:0] pc);
    cte_ucode_t w;
    unique case (pc)
      4'd0:    w = uc(SRC_HEX,   8'h00,   3'd4, 1'b0, 1'b0, LAST_NO,    JMP_NEXT, PC_CHUNK);
      4'd1:    w = uc(SRC_HEX,   8'h00,   3'd3, 1'b0, 1'b0, LAST_NO,    JMP_NEXT, PC_CHUNK);
      4'd2:    w = uc(SRC_HEX,   8'h00,   3'd2, 1'b0, 1'b0, LAST_NO,    JMP_NEXT, PC_CHUNK);
      4'd3:    w = uc(SRC_HEX,   8'h00,   3'd1, 1'b0, 1'b0, LAST_NO,    JMP_NEXT, PC_CHUNK);
      4'd4:    w = uc(SRC_HEX,   8'h00,   3'd0, 1'b0, 1'b0, LAST_NO,    JMP_NEXT, PC_CHUNK);
      4'd5:    w = uc(SRC_CONST, CH_CR,   3'd0, 1'b0, 1'b0, LAST_NO,    JMP_NEXT, PC_CHUNK);
      4'd6:    w = uc(SRC_CONST, CH_LF,   3'd0, 1'b1, 1'b0, LAST_NO,    JMP_NEXT, PC_CHUNK);
      4'd7:    w = uc(SRC_BUF,   8'h00,   3'd0, 1'b0, 1'b1, LAST_NO,    JMP_LOOP, PC_BUF);
      4'd8:    w = uc(SRC_CONST, CH_CR,   3'd0, 1'b0, 1'b0, LAST_NO,    JMP_NEXT, PC_CHUNK);
      4'd9:    w = uc(SRC_CONST, CH_LF,   3'd0, 1'b0, 1'b0, LAST_CHUNK, JMP_TERM, PC_CHUNK);
      4'd10:   w = uc(SRC_CONST, CH_ZERO, 3'd0, 1'b0, 1'b0, LAST_NO,    JMP_NEXT, PC_CHUNK);
      4'd11:   w = uc(SRC_CONST, CH_CR,   3'd0, 1'b0, 1'b0, LAST_NO,    JMP_NEXT, PC_CHUNK);
      4'd12:   w = uc(SRC_CONST, CH_LF,   3'd0, 1'b0, 1'b0, LAST_NO,    JMP_NEXT, PC_CHUNK);
      4'd13:   w = uc(SRC_CONST, CH_CR,   3'd0, 1'b0, 1'b0, LAST_NO,    JMP_NEXT, PC_CHUNK);
      4'd14:   w = uc(SRC_CONST, CH_LF,   3'd0, 1'b0, 1'b0, LAST_YES,   JMP_END,  PC_CHUNK);
      default: w = uc(SRC_CONST, 8'h00,   3'd0, 1'b0, 1'b0, LAST_YES,   JMP_END,  PC_CHUNK);
    endcase
    return w;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h61 + {4'h0, v} - 8'd10);
  endfunction

endpackage

>>> rtl/chunked_transfer_encoder.sv
// Chunked transfer encoder top level: buffer, length counter and output register.
//
// Payload bytes collect in a 32-entry buffer until the chunk size is reached, then the
// chunk goes out as five lowercase hex length digits, CR LF, the data and CR LF; a flush
// sends any partial chunk the same way followed by "0" CR LF CR LF. A byte that does not
// complete a chunk is taken straight into the buffer. Otherwise the microcode sequencer
// issues one output beat per step while the output side does not stall; a chunk of N bytes
// gives N + 9 beats, a flush 5 more, and the input stalls until the last one is issued.
// An accepted flush or filling byte first starts the sequencer, which then issues the first
// beat. The output register lets the next input beat be taken while the last beat waits.
`include "chunked_transfer_encoder_macros.svh"

module chunked_transfer_encoder (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  cte_pkg::cte_in_t        in_item,
  output logic                    out_valid,
  input  logic                    out_stall,
  output cte_pkg::cte_out_t       out_item,
  input  logic                    cfg_we,
  input  logic [cte_pkg::CFG_W-1:0] cfg_wdata
);
  import cte_pkg::*;

  logic [7:0]       buf_mem [MAX_CHUNK];
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CFG_W-1:0] chunk_size_r;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [7:0]       rd_data_r;
  logic             out_valid_r;
  cte_out_t         out_r;

  cte_start_t       start;
  cte_ctrl_t        ctrl;
  logic             accept;
  logic             advance;
  logic             more;
  logic [CNT_W-1:0] eff_size;
  logic [CNT_W-1:0] fill_inc;
  logic [19:0]      len20;
  logic [3:0]       nib_val;
  logic [7:0]       byte_val;

  cte_sequencer u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .advance (advance),
    .more    (more),
    .ctrl    (ctrl)
  );

  assign in_stall = ctrl.busy;
  assign accept   = in_valid && !ctrl.busy;
  assign advance  = !out_valid_r || !out_stall;

  // zero or oversized chunk size falls back to the buffer depth
  assign eff_size = ((chunk_size_r == '0) || (chunk_size_r > CFG_W'(MAX_CHUNK)))
                    ? CNT_W'(MAX_CHUNK) : CNT_W'(chunk_size_r);
  assign fill_inc = fill_r + 1'b1;

  always_comb begin
    start.go    = accept && ((in_item.op == OP_FLUSH) || (fill_inc >= eff_size));
    start.flush = (in_item.op == OP_FLUSH);
    start.addr  = ((in_item.op == OP_FLUSH) && (fill_r == '0)) ? PC_TERM : PC_CHUNK;
    fill_nxt    = fill_r;
    len_nxt     = len_r;
    if (accept) begin
      len_nxt  = (in_item.op == OP_FLUSH) ? fill_r : fill_inc;
      fill_nxt = start.go ? '0 : fill_inc;
    end
  end

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    if (ctrl.fire && ctrl.rd_clear) rd_idx_nxt = '0;
    else if (ctrl.fire && ctrl.rd_inc) rd_idx_nxt = rd_idx_r + 1'b1;
  end

  assign more    = (rd_idx_r + 1'b1) < len_r;
  assign len20   = {{(20 - CNT_W){1'b0}}, len_r};
  assign nib_val = 4'(len20 >> {ctrl.nib, 2'b00});

  always_comb begin
    unique case (ctrl.src)
      SRC_CONST: byte_val = ctrl.const_byte;
      SRC_HEX:   byte_val = hex_char(nib_val);
      SRC_BUF:   byte_val = rd_data_r;
      default:   byte_val = ctrl.const_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      chunk_size_r <= CFG_W'(MAX_CHUNK);
      len_r        <= '0;
      rd_idx_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      fill_r   <= fill_nxt;
      len_r    <= len_nxt;
      rd_idx_r <= rd_idx_nxt;
      if (cfg_we) chunk_size_r <= cfg_wdata;
      if (ctrl.fire) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      out_r.out_byte <= byte_val;
      out_r.last     <= ctrl.last;
    end
  end

  // buffer write on a payload beat, registered read one step ahead of the data loop
  always_ff @(posedge clk) begin
    if (accept && (in_item.op == OP_BYTE)) buf_mem[fill_r[BUF_AW-1:0]] <= in_item.data_byte;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= buf_mem[rd_idx_nxt[BUF_AW-1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `CTE_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_r < CNT_W'(MAX_CHUNK))
  `CTE_ASSERT_IMPL(a_buf_read_range, clk, rst_n, ctrl.fire && (ctrl.src == SRC_BUF),
                   rd_idx_r < len_r)
  `CTE_ASSERT_NEXT(a_fire_valid, clk, rst_n, ctrl.fire, out_valid_r)

endmodule

>>> rtl/cte_sequencer.sv
// Microcode sequencer: step counter, control ROM and jump logic.
`include "chunked_transfer_encoder_macros.svh"

module cte_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  cte_pkg::cte_start_t start,
  input  logic               advance,
  input  logic               more,
  output cte_pkg::cte_ctrl_t ctrl
);
  import cte_pkg::*;

  cte_state_t      state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            flush_r, flush_nxt;
  cte_ucode_t      uw;
  logic            fire;

  assign uw   = ucode_rom(pc_r);
  assign fire = (state_r == SEQ_RUN) && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      pc_r    <= PC_CHUNK;
      flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      flush_r <= flush_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    flush_nxt = flush_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (start.go) begin
          state_nxt = SEQ_RUN;
          pc_nxt    = start.addr;
          flush_nxt = start.flush;
        end
      end
      SEQ_RUN: begin
        if (fire) begin
          unique case (uw.jmp)
            JMP_NEXT: pc_nxt = pc_r + 1'b1;
            JMP_LOOP: pc_nxt = more ? uw.target : pc_r + 1'b1;
            JMP_TERM: begin
              if (flush_r) pc_nxt = pc_r + 1'b1;
              else state_nxt = SEQ_IDLE;
            end
            JMP_END:  state_nxt = SEQ_IDLE;
            default:  state_nxt = SEQ_IDLE;
          endcase
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_comb begin
    ctrl.busy       = (state_r == SEQ_RUN);
    ctrl.fire       = fire;
    ctrl.src        = uw.src;
    ctrl.const_byte = uw.const_byte;
    ctrl.nib        = uw.nib;
    ctrl.rd_clear   = uw.rd_clear;
    ctrl.rd_inc     = uw.rd_inc;
    ctrl.last       = (uw.last == LAST_YES) || ((uw.last == LAST_CHUNK) && !flush_r);
  end

  `CTE_ASSERT_IMPL(a_start_idle, clk, rst_n, start.go, state_r == SEQ_IDLE)
  `CTE_ASSERT_NEXT(a_last_ends, clk, rst_n, fire && ctrl.last, state_r == SEQ_IDLE)
  `CTE_ASSERT_NEXT(a_hold_step, clk, rst_n, (state_r == SEQ_RUN) && !fire, $stable(pc_r))

endmodule
